/* hw/rtl/fed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_pkg
// Shared widths, register map, config type and arithmetic helpers for the
// feedback echo delay core.
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned StoreW   = 24;
  localparam int unsigned PosW     = 16;
  localparam int unsigned LenW     = 17;
  localparam int unsigned AddrW    = 17;
  localparam int unsigned DecayW   = 15;
  localparam int unsigned WetW     = 16;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;
  localparam int unsigned FbProdW  = StoreW + DecayW + 1;
  localparam int unsigned WetProdW = StoreW + WetW + 1;

  localparam logic [LenW-1:0]   MaxDelay  = 17'd65536;
  localparam logic [DecayW-1:0] DecayMax  = 15'd32735;
  localparam logic [WetW-1:0]   WetMax    = 16'd32768;

  localparam logic [LenW-1:0]   DelayRst  = 17'd0;
  localparam logic [1:0]        ChanRst   = 2'd1;
  localparam logic [DecayW-1:0] DecayRst  = 15'd22938;
  localparam logic [WetW-1:0]   WetRst    = 16'd32768;

  localparam logic [2:0] RegDelay = 3'd0;
  localparam logic [2:0] RegChan  = 3'd1;
  localparam logic [2:0] RegDecay = 3'd2;
  localparam logic [2:0] RegWet   = 3'd3;
  localparam logic [2:0] RegRbw   = 3'd4;

  typedef struct packed {
    logic [LenW-1:0]   len;
    logic              two_chan;
    logic [DecayW-1:0] decay;
    logic [WetW-1:0]   wet;
    logic              rbw;
  } cfg_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_new;
  } arith_ctl_t;

  function automatic logic signed [StoreW-1:0] sat_store(
      input logic signed [StoreW+1:0] v);
    logic signed [StoreW+1:0] hi;
    logic signed [StoreW+1:0] lo;
    hi = (StoreW+2)'(8388607);
    lo = -(StoreW+2)'(8388608);
    if (v > hi) begin
      sat_store = StoreW'(hi);
    end else if (v < lo) begin
      sat_store = StoreW'(lo);
    end else begin
      sat_store = v[StoreW-1:0];
    end
  endfunction

  function automatic logic signed [SampleW-1:0] scale_wet(
      input logic signed [WetProdW-1:0] p);
    logic signed [WetProdW-1:0] biased;
    logic signed [WetProdW-1:0] q;
    logic signed [WetProdW-1:0] hi;
    logic signed [WetProdW-1:0] lo;
    biased = p[WetProdW-1] ? (p + WetProdW'(32767)) : p;
    q = biased >>> 15;
    hi = WetProdW'(32767);
    lo = -WetProdW'(32768);
    if (q > hi) begin
      scale_wet = SampleW'(hi);
    end else if (q < lo) begin
      scale_wet = SampleW'(lo);
    end else begin
      scale_wet = q[SampleW-1:0];
    end
  endfunction

endpackage

/* hw/rtl/feedback_echo_delay_core.sv */
`timescale 1ns / 1ps
// Flow: an input word passes the read, update and output states, plus a new-entry multiply
// state unless read-first or bypass is set; the output word is then registered. Words are
// taken one at a time: s_axis_tready stays low until the word has left the output state.
// Reset: clears control state and settings, then sweeps the 131072-entry store
// to zero with s_axis_tready low; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
// feedback_echo_delay_core
// Multichannel feedback echo built around one delay-store RAM.
// ----------------------------------------------------------------------------
module feedback_echo_delay_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // [15:0] sample_in
  input  logic                       s_axis_tlast,
  input  logic                       s_axis_tuser,  // [0] channel_index
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [15:0] sample_out
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fed_pkg::PaddrW-1:0] paddr,
  input  logic [fed_pkg::PdataW-1:0] pwdata,
  output logic [fed_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import fed_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StUpd  = 3'd2;
  localparam logic [2:0] StMulw = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  cfg_t                     cfg;
  arith_ctl_t               ctl;
  logic [2:0]               state_q, state_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [LenW-1:0]          pos_next;
  logic signed [SampleW-1:0] sample_q;
  logic                     last_q;
  logic                     bypass_q;
  logic [AddrW-1:0]         addr_q;
  logic [AddrW-1:0]         rd_addr;
  logic                     ch_eff;
  logic signed [SampleW-1:0] res_q, res_d;
  logic                     m_valid_q;
  logic [SampleW-1:0]       m_data_q;
  logic                     clr_busy;
  logic                     in_acc;
  logic                     out_free;
  logic signed [StoreW-1:0] rd_data;
  logic signed [StoreW-1:0] new_entry;
  logic signed [SampleW-1:0] y_old, y_new;
  logic                     wr_en;

  fed_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign s_axis_tready = (state_q == StIdle) & ~clr_busy;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign ch_eff        = s_axis_tuser & cfg.two_chan;
  assign rd_addr       = {ch_eff, pos_q};
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign wr_en         = (state_q == StUpd) & ~bypass_q;
  assign pos_next      = LenW'(pos_q) + LenW'(1);

  fed_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (new_entry),
    .clr_busy_o(clr_busy)
  );

  fed_arith u_arith (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .cfg_i      (cfg),
    .entry_i    (rd_data),
    .sample_i   (sample_q),
    .new_entry_o(new_entry),
    .y_old_o    (y_old),
    .y_new_o    (y_new)
  );

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    res_d       = res_q;
    ctl.ld_prod = 1'b0;
    ctl.ld_new  = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StRead;
        end
      end
      StRead: begin
        ctl.ld_prod = 1'b1;
        state_d     = StUpd;
      end
      StUpd: begin
        ctl.ld_new = 1'b1;
        if (!bypass_q && last_q) begin
          pos_d = (pos_next >= cfg.len) ? '0 : pos_next[PosW-1:0];
        end
        res_d = bypass_q ? sample_q : y_old;
        state_d = (bypass_q || cfg.rbw) ? StOut : StMulw;
      end
      StMulw: begin
        res_d   = y_new;
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (state_q == StOut && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      sample_q <= $signed(s_axis_tdata);
      last_q   <= s_axis_tlast;
      bypass_q <= (cfg.len == '0);
      addr_q   <= rd_addr;
    end
    if (state_q == StOut && out_free) begin
      m_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* hw/rtl/fed_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_regs
// APB register file: holds the raw settings, reads them back and hands the
// clamped values to the datapath.
// ----------------------------------------------------------------------------
module fed_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fed_pkg::PaddrW-1:0] paddr,
  input  logic [fed_pkg::PdataW-1:0] pwdata,
  output logic [fed_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output fed_pkg::cfg_t              cfg_o
);
  import fed_pkg::*;

  logic [LenW-1:0]   delay_q;
  logic [1:0]        chan_q;
  logic [DecayW-1:0] decay_q;
  logic [WetW-1:0]   wet_q;
  logic              rbw_q;
  logic              wr_en;
  logic [2:0]        idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayRst;
      chan_q  <= ChanRst;
      decay_q <= DecayRst;
      wet_q   <= WetRst;
      rbw_q   <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        RegDelay: delay_q <= pwdata[LenW-1:0];
        RegChan:  chan_q  <= pwdata[1:0];
        RegDecay: decay_q <= pwdata[DecayW-1:0];
        RegWet:   wet_q   <= pwdata[WetW-1:0];
        RegRbw:   rbw_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegDelay: prdata = PdataW'(delay_q);
      RegChan:  prdata = PdataW'(chan_q);
      RegDecay: prdata = PdataW'(decay_q);
      RegWet:   prdata = PdataW'(wet_q);
      RegRbw:   prdata = PdataW'(rbw_q);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.len      = (delay_q > MaxDelay) ? MaxDelay : delay_q;
    cfg_o.two_chan = chan_q[1];
    cfg_o.decay    = (decay_q > DecayMax) ? DecayMax : decay_q;
    cfg_o.wet      = (wet_q > WetMax) ? WetMax : wet_q;
    cfg_o.rbw      = rbw_q;
  end

endmodule

/* hw/rtl/fed_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_store
// Delay store: one synchronous RAM with a registered read port and a single
// write port, swept to zero after reset.
// ----------------------------------------------------------------------------
module fed_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [fed_pkg::AddrW-1:0]        rd_addr_i,
  output logic signed [fed_pkg::StoreW-1:0] rd_data_o,
  input  logic                             wr_en_i,
  input  logic [fed_pkg::AddrW-1:0]        wr_addr_i,
  input  logic signed [fed_pkg::StoreW-1:0] wr_data_i,
  output logic                             clr_busy_o
);
  import fed_pkg::*;

  localparam int unsigned Depth = 2 ** AddrW;

  logic signed [StoreW-1:0] mem [Depth];
  logic [AddrW-1:0]         clr_addr_q;
  logic                     clr_busy_q;
  logic                     we;
  logic [AddrW-1:0]         waddr;
  logic signed [StoreW-1:0] wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (&clr_addr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  assign clr_busy_o = clr_busy_q;

endmodule

/* hw/rtl/fed_arith.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_arith
// Feedback and wet-gain arithmetic: registered feedback and old-entry wet products,
// rounded feedback sum with 24-bit saturation, and 16-bit output scaling.
// ----------------------------------------------------------------------------
module fed_arith (
  input  logic                               clk_i,
  input  fed_pkg::arith_ctl_t                ctl_i,
  input  fed_pkg::cfg_t                      cfg_i,
  input  logic signed [fed_pkg::StoreW-1:0]  entry_i,
  input  logic signed [fed_pkg::SampleW-1:0] sample_i,
  output logic signed [fed_pkg::StoreW-1:0]  new_entry_o,
  output logic signed [fed_pkg::SampleW-1:0] y_old_o,
  output logic signed [fed_pkg::SampleW-1:0] y_new_o
);
  import fed_pkg::*;

  logic signed [FbProdW-1:0]  fb_prod_q;
  logic signed [WetProdW-1:0] wo_prod_q;
  logic signed [StoreW-1:0]   new_q;
  logic signed [FbProdW-1:0]  fb_round;
  logic signed [StoreW+1:0]   fb_sum;
  logic signed [WetProdW-1:0] wn_prod;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_prod) begin
      fb_prod_q <= entry_i * $signed({1'b0, cfg_i.decay});
      wo_prod_q <= entry_i * $signed({1'b0, cfg_i.wet});
    end
  end

  assign fb_round    = (fb_prod_q + FbProdW'(16384)) >>> 15;
  assign fb_sum      = fb_round[StoreW+1:0] + (StoreW+2)'(sample_i);
  assign new_entry_o = sat_store(fb_sum);
  assign y_old_o     = scale_wet(wo_prod_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_new) begin
      new_q <= new_entry_o;
    end
  end

  assign wn_prod = new_q * $signed({1'b0, cfg_i.wet});
  assign y_new_o = scale_wet(wn_prod);

endmodule

/* hw/rtl/fed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_checker
// Port-level checks for the feedback echo delay core, bound to the top level.
// ----------------------------------------------------------------------------
module fed_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("output word without a matching input word");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two words in flight");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

endmodule

bind feedback_echo_delay_core fed_checker u_fed_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* test/feedback_echo_delay_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay_core_test
// Self-checking bench for the feedback echo core. A queue-fed driver and a
// monitor run the stream ports with random gaps and stalls. The APB port
// steps through bypass, long delay, clamped gains, out-of-range channel
// counts, a shrinking delay, store saturation and random settings. A local
// comb-filter model predicts every output word.
// ----------------------------------------------------------------------------
module feedback_echo_delay_core_test;
  import fed_pkg::*;

  localparam int NumChan = 2;
  localparam int StoreDepth = NumChan * 65536;

  typedef struct packed {
    logic        last;
    logic        chan;
    logic [15:0] smp;
  } echo_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PaddrW-1:0]   paddr = '0;
  logic [PdataW-1:0]   pwdata = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  logic signed [StoreW-1:0] echo_mem [0:StoreDepth-1];
  int unsigned              echo_pos = 0;
  logic [LenW-1:0]          cfg_len = DelayRst;
  logic [1:0]               cfg_chan = ChanRst;
  logic [DecayW-1:0]        cfg_decay = DecayRst;
  logic [WetW-1:0]          cfg_wet = WetRst;
  logic                     cfg_rbw = 1'b0;

  echo_word_t  sample_q[$];
  logic [15:0] wet_out_q[$];
  echo_word_t  cur_word;
  int          src_gap = 0;
  int          src_count = 0;
  bit          src_calm = 1'b0;
  int          snk_wait = 0;
  int          snk_count = 0;
  bit          snk_calm = 1'b0;
  int          fail_count = 0;

  feedback_echo_delay_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] comb_filter_step(input echo_word_t w);
    longint      len;
    longint      chans;
    longint      ch;
    longint      decay;
    longint      wet;
    longint      s;
    longint      old_e;
    longint      new_e;
    longint      used;
    longint      y;
    int unsigned addr;
    s = longint'($signed(w.smp));
    len = (cfg_len > MaxDelay) ? MaxDelay : cfg_len;
    if (len == 0) begin
      return w.smp;
    end
    chans = (cfg_chan == 2'd0) ? 1 : cfg_chan;
    if (chans > NumChan) begin
      chans = NumChan;
    end
    ch = w.chan;
    if (ch >= chans) begin
      ch = chans - 1;
    end
    decay = (cfg_decay > DecayMax) ? DecayMax : cfg_decay;
    wet = (cfg_wet > WetMax) ? WetMax : cfg_wet;
    addr = int'(ch) * 65536 + echo_pos;
    old_e = echo_mem[addr];
    new_e = ((old_e * decay + 16384) >>> 15) + s;
    if (new_e > 8388607) begin
      new_e = 8388607;
    end else if (new_e < -8388608) begin
      new_e = -8388608;
    end
    echo_mem[addr] = new_e[StoreW-1:0];
    used = cfg_rbw ? old_e : new_e;
    y = (used * wet) / 32768;
    if (y > 32767) begin
      y = 32767;
    end else if (y < -32768) begin
      y = -32768;
    end
    if (w.last) begin
      echo_pos = (echo_pos + 1 >= len) ? 0 : echo_pos + 1;
    end
    return y[15:0];
  endfunction

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void push_word(input logic [15:0] smp, input logic chan,
                                    input logic last);
    echo_word_t w;
    w.smp = smp;
    w.chan = chan;
    w.last = last;
    sample_q.push_back(w);
  endfunction

  // whole frames with random content, a few stray words mixed in
  function automatic void add_frames(input int n);
    int nch;
    nch = (cfg_chan == 2'd0) ? 1 : ((cfg_chan > NumChan) ? NumChan : cfg_chan);
    while (n > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        push_word(draw_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        n--;
      end else begin
        for (int c = 0; c < nch; c++) begin
          push_word(draw_sample(), 1'(c), c == nch - 1);
          n--;
        end
      end
    end
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [PdataW-1:0] wdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegDelay: cfg_len = wdata[LenW-1:0];
      RegChan:  cfg_chan = wdata[1:0];
      RegDecay: cfg_decay = wdata[DecayW-1:0];
      RegWet:   cfg_wet = wdata[WetW-1:0];
      RegRbw:   cfg_rbw = wdata[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || s_axis_tvalid || wet_out_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_settings();
    logic [LenW-1:0]   len;
    logic [DecayW-1:0] decay;
    logic [WetW-1:0]   wet;
    case ($urandom_range(0, 9))
      0: len = '0;
      1: len = MaxDelay;
      2: len = '1;
      3: len = LenW'($urandom());
      default: len = LenW'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 4))
      0: decay = '0;
      1: decay = DecayMax;
      2: decay = '1;
      default: decay = DecayW'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0: wet = '0;
      1: wet = WetMax;
      2: wet = '1;
      default: wet = WetW'($urandom());
    endcase
    reg_write(RegDecay, PdataW'(decay));
    reg_write(RegWet, PdataW'(wet));
    reg_write(RegDelay, PdataW'(len));
    reg_write(RegChan, PdataW'($urandom_range(0, 3)));
    reg_write(RegRbw, PdataW'($urandom_range(0, 1)));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        wet_out_q.push_back(comb_filter_step(cur_word));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur_word = sample_q.pop_front();
          s_axis_tdata <= cur_word.smp;
          s_axis_tuser <= cur_word.chan;
          s_axis_tlast <= cur_word.last;
          s_axis_tvalid <= 1'b1;
          if (src_count % 32 == 0) begin
            src_calm = ($urandom_range(0, 2) == 0);
          end
          src_count++;
          src_gap <= src_calm ? 0 : $urandom_range(0, 16);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : sink_proc
    logic [15:0] want;
    int          stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (wet_out_q.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected output word %h", m_axis_tdata);
        end
        fail_count++;
      end else begin
        want = wet_out_q.pop_front();
        if (m_axis_tdata !== want) begin
          if (fail_count < 10) begin
            $display("sample_out mismatch: expected %0d, got %0d", $signed(want),
                     $signed(m_axis_tdata));
          end
          fail_count++;
        end
      end
      if (snk_count % 32 == 0) begin
        snk_calm = ($urandom_range(0, 2) == 0);
      end
      snk_count++;
      stall = snk_calm ? 0 : $urandom_range(0, 16);
      snk_wait <= stall;
      m_axis_tready <= (stall == 0);
    end else if (snk_wait != 0) begin
      snk_wait <= snk_wait - 1;
      m_axis_tready <= (snk_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : main_proc
    for (int i = 0; i < StoreDepth; i++) begin
      echo_mem[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bypass under reset settings
    push_word(16'h7FFF, 1'b0, 1'b0);
    push_word(16'h8000, 1'b1, 1'b1);
    push_word(16'h0000, 1'b0, 1'b1);
    push_word(16'hFFFF, 1'b1, 1'b0);
    wait_idle();

    // two channels, read-first, advance the position past the later length
    reg_write(RegDelay, 32'd8);
    reg_write(RegChan, 32'd2);
    reg_write(RegRbw, 32'd1);
    for (int f = 0; f < 5; f++) begin
      push_word(draw_sample(), 1'b0, 1'b0);
      push_word(draw_sample(), 1'b1, 1'b1);
    end
    wait_idle();

    // shrink the delay, clamp both gains
    reg_write(RegDelay, 32'd3);
    reg_write(RegRbw, 32'd0);
    reg_write(RegDecay, 32'hFFFF_FFFF);
    reg_write(RegWet, 32'hFFFF_FFFF);
    for (int f = 0; f < 3; f++) begin
      push_word(draw_sample(), 1'b0, 1'b0);
      push_word(draw_sample(), 1'b1, 1'b1);
    end
    wait_idle();

    // zero channel count, long delay, writes to unmapped addresses
    reg_write(RegChan, 32'd0);
    reg_write(RegDelay, 32'h0001_FFFF);
    for (int k = RegRbw + 1; k < 8; k++) begin
      reg_write(3'(k), $urandom());
    end
    push_word(16'h1234, 1'b1, 1'b1);
    push_word(16'h8000, 1'b0, 1'b1);
    wait_idle();

    // drive both store channels into saturation
    reg_write(RegDelay, 32'd1);
    reg_write(RegChan, 32'd3);
    reg_write(RegDecay, PdataW'(DecayMax));
    reg_write(RegWet, PdataW'(WetMax));
    reg_write(RegRbw, PdataW'($urandom_range(0, 1)));
    for (int f = 0; f < 330; f++) begin
      push_word(16'h7FFF, 1'b0, 1'b0);
      push_word(16'h8000, 1'b1, 1'b1);
    end
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      random_settings();
      add_frames(100);
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS feedback_echo_delay_core");
    end else begin
      $display("FAIL feedback_echo_delay_core");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL feedback_echo_delay_core");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/fed_pkg.sv
hw/rtl/fed_regs.sv
hw/rtl/fed_store.sv
hw/rtl/fed_arith.sv
hw/rtl/feedback_echo_delay_core.sv
hw/rtl/fed_checker.sv
test/feedback_echo_delay_core_test.sv
